@@ rtl/core/decimal_rounding_unit_core_macros.svh @@
// Assertion macros for the decimal rounding unit checker.
// Clocked on clk_i, disabled while rst_ni is low; no other dependencies.
`ifndef DECIMAL_ROUNDING_UNIT_CORE_MACROS_SVH
`define DECIMAL_ROUNDING_UNIT_CORE_MACROS_SVH

// plain property, checked on every rising clock edge out of reset
`define DRU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// overlapping implication
`define DRU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/dru_pkg.sv @@
// Shared types, constants and step table for the decimal rounding unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dru_pkg;

  localparam int FRAC_DIGITS = 6;
  localparam int VALUE_BITS  = 48;
  localparam int PLACES_W    = 3;
  localparam int MODE_W      = 3;
  localparam int PLACES_RESET = 2;
  localparam int NUM_PLACES  = 2 ** PLACES_W;

  function automatic longint unsigned dru_pow10(input int k);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < k; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  localparam longint unsigned MAX_Q = dru_pow10(FRAC_DIGITS);
  localparam int REM_W = $clog2(MAX_Q + 1);

  // input, cell row, rounding stage, output
  localparam int DRU_LATENCY = VALUE_BITS + 3;

  typedef logic [REM_W-1:0] dru_rem_t;
  typedef dru_rem_t dru_step_tbl_t [NUM_PLACES];

  function automatic dru_step_tbl_t dru_build_steps();
    dru_step_tbl_t tbl;
    for (int k = 0; k < NUM_PLACES; k++) begin
      if (k >= FRAC_DIGITS) begin
        tbl[k] = dru_rem_t'(1);
      end else begin
        tbl[k] = dru_rem_t'(dru_pow10(FRAC_DIGITS - k));
      end
    end
    return tbl;
  endfunction

  localparam dru_step_tbl_t STEP_TBL = dru_build_steps();

  localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef enum logic [MODE_W-1:0] {
    MODE_CEIL0      = 3'd0,
    MODE_FLOOR0     = 3'd1,
    MODE_HALF_UP    = 3'd2,
    MODE_HALF_UP0   = 3'd3,
    MODE_HALF_DOWN  = 3'd4,
    MODE_HALF_DOWN0 = 3'd5,
    MODE_HALF_EVEN  = 3'd6
  } dru_mode_e;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [MODE_W-1:0]            mode;
  } dru_in_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] rounded;
    logic                         overflow;
  } dru_out_t;

  // one transaction as it moves along the division row
  typedef struct packed {
    logic                  neg;
    logic [MODE_W-1:0]     mode;
    logic [VALUE_BITS-1:0] mag;
    logic [VALUE_BITS-1:0] work;
    dru_rem_t              rem;
  } dru_slot_t;

endpackage

@@ rtl/core/dru_cell.sv @@
// One restoring division cell: develops one quotient bit per transaction.
// Depends on dru_pkg.
`timescale 1ns / 1ps

module dru_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  dru_pkg::dru_slot_t slot_i,
  input  dru_pkg::dru_rem_t  q_i,
  output logic              valid_o,
  output dru_pkg::dru_slot_t slot_o
);
  import dru_pkg::*;

  logic              valid_q;
  dru_slot_t         slot_q, slot_d;
  logic [REM_W:0]    rem_sh;
  logic              ge;

  always_comb begin
    rem_sh = {slot_i.rem, slot_i.work[VALUE_BITS-1]};
    ge     = rem_sh >= {1'b0, q_i};
    slot_d = slot_i;
    slot_d.work = {slot_i.work[VALUE_BITS-2:0], ge};
    if (ge) begin
      slot_d.rem = dru_rem_t'(rem_sh - {1'b0, q_i});
    end else begin
      slot_d.rem = rem_sh[REM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign valid_o = valid_q;
  assign slot_o  = slot_q;

endmodule

@@ rtl/core/dru_round.sv @@
// Rounding decision, saturation and output registers at the end of the cell row.
// Depends on dru_pkg.
`timescale 1ns / 1ps

module dru_round (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  dru_pkg::dru_slot_t slot_i,
  input  dru_pkg::dru_rem_t  q_i,
  input  logic               bypass_i,
  output logic               done_o,
  output dru_pkg::dru_out_t  result_o
);
  import dru_pkg::*;

  localparam logic [VALUE_BITS:0] TOP = {2'b01, {(VALUE_BITS-1){1'b0}}};

  logic                  up;
  logic [REM_W:0]        r2, qx;
  logic                  tie, above;
  logic [VALUE_BITS:0]   sum_d, sum_q;
  logic                  neg_q;
  logic                  valid_a_q;
  logic                  done_q;
  dru_out_t              res_d, res_q;
  logic [VALUE_BITS:0]   sat;
  logic [VALUE_BITS-1:0] mag_out;

  always_comb begin
    r2    = {slot_i.rem, 1'b0};
    qx    = {1'b0, q_i};
    tie   = r2 == qx;
    above = r2 > qx;
    case (dru_mode_e'(slot_i.mode))
      MODE_CEIL0:      up = slot_i.rem != '0;
      MODE_FLOOR0:     up = 1'b0;
      MODE_HALF_UP:    up = above || (tie && !slot_i.neg);
      MODE_HALF_UP0:   up = above || tie;
      MODE_HALF_DOWN:  up = above || (tie && slot_i.neg);
      MODE_HALF_DOWN0: up = above;
      default:         up = above || (tie && slot_i.work[0]);
    endcase
    if (bypass_i) begin
      sum_d = {1'b0, slot_i.mag};
    end else begin
      sum_d = {1'b0, slot_i.mag}
            - {{(VALUE_BITS+1-REM_W){1'b0}}, slot_i.rem}
            + (up ? {{(VALUE_BITS+1-REM_W){1'b0}}, q_i} : '0);
    end
  end

  always_comb begin
    res_d.overflow = 1'b0;
    sat            = sum_q;
    if (neg_q) begin
      if (sum_q > TOP) begin
        sat            = TOP;
        res_d.overflow = 1'b1;
      end
    end else begin
      if (sum_q >= TOP) begin
        sat            = TOP - 1'b1;
        res_d.overflow = 1'b1;
      end
    end
    mag_out       = sat[VALUE_BITS-1:0];
    res_d.rounded = neg_q ? (~mag_out + 1'b1) : mag_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
      done_q    <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    neg_q <= slot_i.neg;
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

@@ rtl/core/decimal_rounding_unit_core.sv @@
// Top level of the decimal rounding unit: input register, division cell row, rounding stage.
// Depends on dru_pkg, dru_cell and dru_round.
`timescale 1ns / 1ps

// Rounds a signed fixed-point decimal value (scale 10^FRAC_DIGITS) to the configured
// number of decimal places under one of seven rounding modes, saturating on overflow.
// A transaction is taken on every clock edge with start_i high; busy_o stays low, so
// the unit sustains one transaction per cycle. Each result appears on result_o with
// done_o high for exactly one cycle, after its start has passed through one input register,
// a row of VALUE_BITS restoring division cells that each settle one quotient bit, a rounding
// register and an output register. Results cannot be held off and leave in start order.
// Write cfg_data_i with cfg_we_i only while no transaction is in flight; reset selects
// two decimal places.
module decimal_rounding_unit_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  dru_pkg::dru_in_t              in_i,
  output logic                          done_o,
  output dru_pkg::dru_out_t             result_o,
  input  logic                          cfg_we_i,
  input  logic [dru_pkg::PLACES_W-1:0]  cfg_data_i
);
  import dru_pkg::*;

  dru_rem_t  q_q, q_d;
  logic      bypass_q, bypass_d;
  logic      in_valid_q;
  dru_slot_t in_slot_q, in_slot_d;
  logic [VALUE_BITS-1:0] raw;

  logic      valid_w [VALUE_BITS+1];
  dru_slot_t slot_w  [VALUE_BITS+1];

  always_comb begin
    q_d      = STEP_TBL[cfg_data_i];
    bypass_d = int'(cfg_data_i) >= FRAC_DIGITS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q      <= STEP_TBL[PLACES_RESET];
      bypass_q <= PLACES_RESET >= FRAC_DIGITS;
    end else if (cfg_we_i) begin
      q_q      <= q_d;
      bypass_q <= bypass_d;
    end
  end

  assign busy_o = 1'b0;

  always_comb begin
    raw            = in_i.value;
    in_slot_d.neg  = raw[VALUE_BITS-1];
    in_slot_d.mode = in_i.mode;
    in_slot_d.mag  = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
    in_slot_d.work = in_slot_d.mag;
    in_slot_d.rem  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    in_slot_q <= in_slot_d;
  end

  assign valid_w[0] = in_valid_q;
  assign slot_w[0]  = in_slot_q;

  for (genvar g = 0; g < VALUE_BITS; g++) begin : g_cell
    dru_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_w[g]),
      .slot_i  (slot_w[g]),
      .q_i     (q_q),
      .valid_o (valid_w[g+1]),
      .slot_o  (slot_w[g+1])
    );
  end

  dru_round u_round (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_w[VALUE_BITS]),
    .slot_i   (slot_w[VALUE_BITS]),
    .q_i      (q_q),
    .bypass_i (bypass_q),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

@@ rtl/core/dru_checker.sv @@
// Port-level checker for the decimal rounding unit, bound to the top level.
// Depends on dru_pkg and decimal_rounding_unit_core_macros.svh.
`timescale 1ns / 1ps
`include "decimal_rounding_unit_core_macros.svh"

module dru_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o,
  input dru_pkg::dru_out_t result_o
);
  import dru_pkg::*;

  `DRU_ASSERT_IMP(a_done_follows_start, start_i && !busy_o, ##DRU_LATENCY done_o, "transaction lost")
  `DRU_ASSERT_IMP(a_start_precedes_done, done_o, $past(start_i && !busy_o, DRU_LATENCY), "spurious result")
  `DRU_ASSERT_IMP(a_overflow_saturates, done_o && result_o.overflow, result_o.rounded == VALUE_MAX || result_o.rounded == VALUE_MIN, "overflow without saturation")

endmodule

bind decimal_rounding_unit_core dru_checker u_dru_checker (.*);

@@ bench/decimal_rounding_unit_core_test.sv @@
// Self-checking bench for decimal_rounding_unit_core: directed and random roundings across
// every decimal-places setting, with results predicted in a scoreboard class.
// Depends on dru_pkg and decimal_rounding_unit_core only.
`timescale 1ns / 1ps

module decimal_rounding_unit_core_test;
  import dru_pkg::*;

  class rounding_scoreboard;
    dru_out_t    expected_q[$];
    int unsigned places;
    int unsigned errors;

    function new();
      places = PLACES_RESET;
      errors = 0;
    endfunction

    static function longint unsigned step_of(int unsigned p);
      longint unsigned s;
      s = 1;
      if (p < FRAC_DIGITS) begin
        for (int unsigned i = p; i < FRAC_DIGITS; i++) begin
          s = s * 10;
        end
      end
      return s;
    endfunction

    function dru_out_t round_value(dru_in_t d);
      logic [VALUE_BITS-1:0] raw;
      logic                  neg;
      longint unsigned       mag, q, t, r, res, limit, signed_res;
      logic                  tie, above, up;
      dru_out_t              o;
      raw = d.value;
      neg = raw[VALUE_BITS-1];
      mag = neg ? ((64'd1 << VALUE_BITS) - 64'(raw)) : 64'(raw);
      o.overflow = 1'b0;
      if (places >= FRAC_DIGITS) begin
        o.rounded = raw;
        return o;
      end
      q = step_of(places);
      t = mag / q;
      r = mag % q;
      tie = (2 * r == q);
      above = (2 * r > q);
      case (d.mode)
        MODE_CEIL0:      up = (r != 0);
        MODE_FLOOR0:     up = 1'b0;
        MODE_HALF_UP:    up = above || (tie && !neg);
        MODE_HALF_UP0:   up = above || tie;
        MODE_HALF_DOWN:  up = above || (tie && neg);
        MODE_HALF_DOWN0: up = above;
        default:         up = above || (tie && t[0]);
      endcase
      res = (up ? t + 1 : t) * q;
      limit = neg ? (64'd1 << (VALUE_BITS - 1)) : ((64'd1 << (VALUE_BITS - 1)) - 1);
      if (res > limit) begin
        res = limit;
        o.overflow = 1'b1;
      end
      signed_res = neg ? (64'd0 - res) : res;
      o.rounded = signed_res[VALUE_BITS-1:0];
      return o;
    endfunction

    function void note_input(dru_in_t d);
      expected_q.push_back(round_value(d));
    endfunction

    function void check_result(dru_out_t got);
      dru_out_t want;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual rounded %0d overflow %0b",
                 $time, $signed(got.rounded), got.overflow);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.rounded !== want.rounded) begin
        $display("%0t rounded: expected %0d, actual %0d",
                 $time, $signed(want.rounded), $signed(got.rounded));
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $display("%0t overflow: expected %0b, actual %0b", $time, want.overflow, got.overflow);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni     = 1'b0;
  logic                start_i    = 1'b0;
  logic                busy_o;
  dru_in_t             in_i       = '0;
  logic                done_o;
  dru_out_t            result_o;
  logic                cfg_we_i   = 1'b0;
  logic [PLACES_W-1:0] cfg_data_i = '0;

  rounding_scoreboard sb = new();

  decimal_rounding_unit_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .in_i       (in_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        sb.check_result(result_o);
      end
      if (cfg_we_i) begin
        sb.places = 32'(cfg_data_i);
      end
      if (start_i && !busy_o) begin
        sb.note_input(in_i);
      end
    end
  end

  task automatic send_value(input logic [VALUE_BITS-1:0] v, input logic [MODE_W-1:0] md,
                            input bit no_gaps);
    int unsigned g, pick;
    g = 0;
    if (!no_gaps) begin
      pick = $urandom_range(0, 99);
      if (pick >= 90) begin
        g = $urandom_range(8, 40);
      end else if (pick >= 55) begin
        g = $urandom_range(1, 3);
      end
    end
    if (g != 0) begin
      start_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i.value <= v;
    in_i.mode <= md;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_places(input logic [PLACES_W-1:0] p);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= p;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned     phase_places[10];
    int unsigned     kind;
    bit              no_gaps;
    bit              neg;
    longint unsigned q, mag, signed_mag;
    longint signed   delta;
    logic [63:0]     wide;

    phase_places = '{0, 7, 6, 5, 1, 3, 4, 2, 0, 1};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting keeps two places: a step of 10000, ties at 5000
    for (int m = 0; m < 2 ** MODE_W; m++) begin
      send_value(VALUE_BITS'(5000), MODE_W'(m), 1'b0);
      send_value(VALUE_BITS'(-15000), MODE_W'(m), 1'b0);
    end
    send_value(VALUE_MAX, MODE_CEIL0, 1'b0);
    send_value(VALUE_MIN, MODE_CEIL0, 1'b0);
    send_value(VALUE_MIN, MODE_HALF_UP0, 1'b0);
    send_value('0, MODE_FLOOR0, 1'b0);
    send_value(VALUE_BITS'(4999), MODE_HALF_UP, 1'b0);
    send_value(VALUE_BITS'(-5001), MODE_HALF_DOWN0, 1'b0);
    send_value(VALUE_BITS'(1), MODE_CEIL0, 1'b0);
    send_value(VALUE_BITS'(-1), MODE_CEIL0, 1'b0);

    foreach (phase_places[ph]) begin
      write_places(PLACES_W'(phase_places[ph]));
      q = rounding_scoreboard::step_of(phase_places[ph]);
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (123) begin
        kind = $urandom_range(0, 9);
        neg = 1'($urandom_range(0, 1));
        delta = longint'($urandom_range(0, 2)) - 1;
        case (kind)
          0, 1: begin
            wide = {$urandom, $urandom};
            mag = 64'(wide[VALUE_BITS-1:0]);
            neg = 1'b0;
          end
          2, 3, 4: mag = longint'($urandom_range(0, 1000)) * q + q / 2 + delta;
          5: mag = ((64'd1 << (VALUE_BITS - 1)) / q - 64'($urandom_range(0, 2))) * q
                   + q / 2 + delta;
          6: mag = (64'd1 << (VALUE_BITS - 1)) - 64'($urandom_range(0, 32'(2 * q)));
          7: mag = (64'd1 << (VALUE_BITS - 1)) - 1 - 64'($urandom_range(0, 32'(2 * q)));
          default: mag = 64'($urandom_range(0, 32'(3 * q)));
        endcase
        signed_mag = neg ? (64'd0 - mag) : mag;
        send_value(signed_mag[VALUE_BITS-1:0], MODE_W'($urandom_range(0, 2 ** MODE_W - 1)),
                   no_gaps);
      end
    end

    drain();
    repeat (DRU_LATENCY + 8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("decimal_rounding_unit_core: match");
    end else begin
      $display("decimal_rounding_unit_core: mismatch");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("decimal_rounding_unit_core: mismatch");
    $finish;
  end

endmodule
